// ----- design/oor_pkg.sv -----
// shared types and constants for the overcurrent retry output block
package oor_pkg;

  // default number of output channels
  localparam int unsigned MaxChannelsDef = 8;

  // field widths
  localparam int unsigned KindW    = 2;
  localparam int unsigned ChannelW = 4;
  localparam int unsigned FlagsW   = 8;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned CntW     = 4;

  // register reset values
  localparam logic [CfgW-1:0] ChannelsRst = 4'd8;
  localparam logic [CfgW-1:0] RetryRst    = 4'd10;

  // item kinds
  typedef enum logic [KindW-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_CHANNELS = 1'b0,
    CFG_RETRY    = 1'b1
  } cfg_idx_e;

endpackage

// ----- design/oor_if.sv -----
// valid/ready channel interfaces for input and result items
interface oor_in_if
  import oor_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [ChannelW-1:0] channel;
  logic                level;
  logic [FlagsW-1:0]   overcurrent_flags;

  modport source (output valid, kind, channel, level, overcurrent_flags, input ready);
  modport sink   (input valid, kind, channel, level, overcurrent_flags, output ready);
endinterface

interface oor_out_if
  import oor_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FlagsW-1:0] drive_levels;
  logic [FlagsW-1:0] fault_flags;
  logic              invalid_channel;

  modport source (output valid, drive_levels, fault_flags, invalid_channel, input ready);
  modport sink   (input valid, drive_levels, fault_flags, invalid_channel, output ready);
endinterface

// ----- design/output_overcurrent_retry.sv -----
// digital outputs with overcurrent hiccup retry, one item per cycle while results are drained
//
//   channel | dir | payload
//   --------+-----+-----------------------------------------------
//   in_i    | in  | kind, channel, level, overcurrent_flags
//   out_o   | out | drive_levels, fault_flags, invalid_channel
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// channel state and the result register update together at the accepting edge,
// and the result shows in the next cycle. an item is taken whenever the result
// register is empty or being drained, so a steady stream moves at one item per
// cycle.
// reset clears all channel state (outputs low) and loads the register defaults.
module output_overcurrent_retry
  import oor_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [0:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  oor_in_if.sink          in_i,
  oor_out_if.source       out_o
);

  localparam int unsigned NumW = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CmpW = (NumW > ChannelW) ? NumW : ChannelW;
  localparam int unsigned OutN = (MAX_CHANNELS < FlagsW) ? MAX_CHANNELS : FlagsW;

  // configuration registers
  logic [CfgW-1:0] chan_cfg_q, retry_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cfg_q  <= ChannelsRst;
      retry_cfg_q <= RetryRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CHANNELS: chan_cfg_q  <= cfg_data_i;
        CFG_RETRY:    retry_cfg_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // active channel count, saturated to the channel storage
  logic [CmpW-1:0] active_n;
  logic [CmpW-1:0] ch_ext;
  logic            ch_ok;

  always_comb begin
    if (CmpW'(chan_cfg_q) > CmpW'(MAX_CHANNELS)) begin
      active_n = CmpW'(MAX_CHANNELS);
    end else begin
      active_n = CmpW'(chan_cfg_q);
    end
  end

  assign ch_ext = CmpW'(in_i.channel);
  assign ch_ok  = ch_ext < active_n;

  // handshake
  logic out_valid_q;
  logic in_acc;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // channel state
  logic [MAX_CHANNELS-1:0]           user_q, user_d;
  logic [MAX_CHANNELS-1:0]           drive_q, drive_d;
  logic [MAX_CHANNELS-1:0][CntW-1:0] cnt_q, cnt_d;

  // per-channel next state
  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    logic            oc;
    logic            sel;
    logic            lane_on;
    logic            user_n, drive_n;
    logic [CntW-1:0] cnt_n;

    if (i < FlagsW) begin : g_flag
      assign oc = in_i.overcurrent_flags[i];
    end else begin : g_noflag
      assign oc = 1'b0;
    end

    assign sel     = ch_ok && (ch_ext == CmpW'(i));
    assign lane_on = CmpW'(i) < active_n;

    always_comb begin
      user_n  = user_q[i];
      drive_n = drive_q[i];
      cnt_n   = cnt_q[i];
      case (kind_e'(in_i.kind))
        KIND_WRITE: begin
          if (sel) begin
            user_n  = in_i.level;
            drive_n = in_i.level;
          end
        end
        KIND_TOGGLE: begin
          if (sel) begin
            user_n  = ~drive_q[i];
            drive_n = ~drive_q[i];
          end
        end
        KIND_TICK: begin
          if (lane_on) begin
            if (oc) begin
              // fault: force low and start the retry count
              drive_n = 1'b0;
              cnt_n   = CntW'(1);
            end else if (cnt_q[i] != '0 && cnt_q[i] >= retry_cfg_q) begin
              // retry time over: restore the stored level
              cnt_n   = '0;
              drive_n = user_q[i];
            end else if (cnt_q[i] != '0) begin
              cnt_n = cnt_q[i] + CntW'(1);
            end
          end
        end
        default: ;
      endcase
    end

    assign user_d[i]  = user_n;
    assign drive_d[i] = drive_n;
    assign cnt_d[i]   = cnt_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_q  <= '0;
      drive_q <= '0;
      cnt_q   <= '0;
    end else if (in_acc) begin
      user_q  <= user_d;
      drive_q <= drive_d;
      cnt_q   <= cnt_d;
    end
  end

  // result bits for the first channels
  logic [FlagsW-1:0] res_drive_d, res_fault_d;
  logic              res_inv_d;

  for (genvar j = 0; j < FlagsW; j++) begin : g_res
    if (j < OutN) begin : g_used
      assign res_drive_d[j] = drive_d[j];
      assign res_fault_d[j] = cnt_d[j] != '0;
    end else begin : g_unused
      assign res_drive_d[j] = 1'b0;
      assign res_fault_d[j] = 1'b0;
    end
  end

  assign res_inv_d = ((kind_e'(in_i.kind) == KIND_WRITE) ||
                      (kind_e'(in_i.kind) == KIND_TOGGLE)) && !ch_ok;

  // result register
  logic [FlagsW-1:0] res_drive_q, res_fault_q;
  logic              res_inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_drive_q <= res_drive_d;
      res_fault_q <= res_fault_d;
      res_inv_q   <= res_inv_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.drive_levels    = res_drive_q;
  assign out_o.fault_flags     = res_fault_q;
  assign out_o.invalid_channel = res_inv_q;

endmodule

// ----- design/oor_checker.sv -----
// port-level checks for the overcurrent retry output block
module oor_checker
  import oor_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [KindW-1:0]  in_kind_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [FlagsW-1:0] out_drive_i,
  input logic [FlagsW-1:0] out_fault_i,
  input logic              out_invalid_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_drive_i) &&
    $stable(out_fault_i) && $stable(out_invalid_i))
    else $error("stalled result changed");

  // an accepted item shows its result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item gave no result");

  // the input side never waits on an empty result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  // a tick never reports an invalid channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && kind_e'(in_kind_i) == KIND_TICK |=> !out_invalid_i)
    else $error("tick reported invalid channel");

endmodule

bind output_overcurrent_retry oor_checker u_oor_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_kind_i     (in_i.kind),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_drive_i   (out_o.drive_levels),
  .out_fault_i   (out_o.fault_flags),
  .out_invalid_i (out_o.invalid_channel)
);
